[rtl/core/rifc_pkg.sv]
// Shared types, register codes and reset values for the range image feature classifier.
// No dependencies; the front end, back end, top level and checker import this package.
`default_nettype none
package rifc_pkg;

    localparam int LINE_MAX_DEF       = 2048;
    localparam int RANGE_BITS_DEF     = 16;
    localparam int INTENSITY_BITS_DEF = 16;
    localparam int RANGE_BITS_MAX     = 24;
    localparam int INTENSITY_BITS_MAX = 24;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register index codes, byte address is four times the index.
    localparam logic [2:0] REG_LINE_WIDTH       = 3'd0;
    localparam logic [2:0] REG_EDGE_THRESHOLD   = 3'd1;
    localparam logic [2:0] REG_SURFACE_THRESH   = 3'd2;
    localparam logic [2:0] REG_GRADIENT_THRESH  = 3'd3;
    localparam logic [2:0] REG_EDGE_LIMIT       = 3'd4;
    localparam logic [2:0] REG_SURFACE_LIMIT    = 3'd5;
    localparam logic [2:0] REG_INTENSITY_LIMIT  = 3'd6;
    localparam logic [2:0] REG_INTENSITY_ENABLE = 3'd7;

    localparam logic [11:0] LINE_WIDTH_RST       = 12'd1024;
    localparam logic [15:0] EDGE_THRESHOLD_RST   = 16'd410;
    localparam logic [15:0] SURFACE_THRESH_RST   = 16'd82;
    localparam logic [15:0] GRADIENT_THRESH_RST  = 16'd2560;
    localparam logic [15:0] EDGE_LIMIT_RST       = 16'd1000;
    localparam logic [15:0] SURFACE_LIMIT_RST    = 16'd4000;
    localparam logic [15:0] INTENSITY_LIMIT_RST  = 16'd1000;

    localparam logic [1:0] CLASS_NONE    = 2'd0;
    localparam logic [1:0] CLASS_EDGE    = 2'd1;
    localparam logic [1:0] CLASS_SURFACE = 2'd2;

    typedef struct packed {
        logic [15:0] pixel_range;
        logic [15:0] pixel_intensity;
        logic        frame_start;
    } in_t;

    typedef struct packed {
        logic [10:0] center_col;
        logic [11:0] center_row;
        logic [1:0]  geom_class;
        logic        intensity_feature;
    } out_t;

    typedef struct packed {
        logic [11:0] line_width;
        logic [15:0] edge_threshold;
        logic [15:0] surface_threshold;
        logic [15:0] gradient_threshold;
        logic [15:0] edge_limit;
        logic [15:0] surface_limit;
        logic [15:0] intensity_limit;
        logic        intensity_enable;
    } cfg_t;

    // One classified neighborhood handed from the front end to the back end.
    typedef struct packed {
        logic [10:0]                      col;
        logic [11:0]                      row;
        logic [RANGE_BITS_MAX-1:0]        rc;
        logic [RANGE_BITS_MAX+2:0]        diff;
        logic [INTENSITY_BITS_MAX+2:0]    grad;
        logic [3:0]                       cnt;
        logic                             clr;
    } entry_t;

endpackage
`default_nettype wire

[rtl/core/rifc_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module rifc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire                       aclk,
    input  wire                       we,
    input  wire  [$clog2(DEPTH)-1:0]  waddr,
    input  wire  [WIDTH-1:0]          wdata,
    input  wire                       re,
    input  wire  [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/core/rifc_fifo.sv]
// Small register FIFO with show-ahead output, used between front and back end.
// No dependencies.
`default_nettype none
module rifc_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               push,
    input  wire  [WIDTH-1:0]  wdata,
    output logic              full,
    input  wire               pop,
    output logic [WIDTH-1:0]  rdata,
    output logic              empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wp_reg, rp_reg;
    logic [CW-1:0]    cnt_reg;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = slot_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        if (push) begin
            slot_reg[wp_reg] <= wdata;
        end
    end
endmodule
`default_nettype wire

[rtl/core/rifc_front.sv]
// Front end: pixel position tracking, line store RAMs, 3x3 window and neighborhood sums.
// Depends on rifc_pkg and rifc_ram.
`default_nettype none
module rifc_front #(
    parameter int LINE_MAX       = 2048,
    parameter int RANGE_BITS     = 16,
    parameter int INTENSITY_BITS = 16
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  rifc_pkg::in_t         s_data,
    input  wire  [11:0]           line_width,
    output logic                  q_push,
    output rifc_pkg::entry_t      q_data,
    input  wire                   q_full
);
    import rifc_pkg::*;

    localparam int PW = RANGE_BITS + INTENSITY_BITS;
    localparam int AW = $clog2(LINE_MAX);
    localparam int WW = 14;
    localparam int DW = RANGE_BITS + 3;
    localparam int GW = INTENSITY_BITS + 3;

    typedef enum logic [1:0] {F_IDLE, F_READ, F_WIN, F_SUM} fstate_t;

    fstate_t          state_reg, state_next;
    logic [10:0]      col_reg, col_next;
    logic [11:0]      row_reg, row_next;
    logic [10:0]      c_reg, c_next;
    logic [11:0]      r_reg, r_next;
    logic             inwin_reg, inwin_next;
    logic             clr_reg, clr_next;
    logic [PW-1:0]    cur_reg, cur_next;
    logic [PW-1:0]    win_reg [9];
    logic [PW-1:0]    win_next [9];

    logic [PW-1:0]    mid_rd, top_rd;
    logic             accept;
    logic [10:0]      c0;
    logic [11:0]      r0;
    logic [WW-1:0]    lw, weff, cplus;

    logic [RANGE_BITS-1:0]     rc, rn;
    logic [INTENSITY_BITS-1:0] ic, inn;
    logic [DW-1:0]             diff;
    logic [GW-1:0]             grad;
    logic [3:0]                cnt;
    logic                      ok;

    // Line store: ram0 holds the previous row, ram1 the row before it.
    rifc_ram #(.WIDTH(PW), .DEPTH(LINE_MAX)) u_ram0 (
        .aclk (aclk),
        .we   (state_reg == F_WIN),
        .waddr(AW'(c_reg)),
        .wdata(cur_reg),
        .re   (state_reg == F_READ),
        .raddr(AW'(c_reg)),
        .rdata(mid_rd)
    );

    rifc_ram #(.WIDTH(PW), .DEPTH(LINE_MAX)) u_ram1 (
        .aclk (aclk),
        .we   (state_reg == F_WIN),
        .waddr(AW'(c_reg)),
        .wdata(mid_rd),
        .re   (state_reg == F_READ),
        .raddr(AW'(c_reg)),
        .rdata(top_rd)
    );

    assign s_ready = (state_reg == F_IDLE);
    assign accept  = s_valid && s_ready;

    // Neighborhood sums over the eight neighbors with a nonzero range.
    always_comb begin
        rc   = win_reg[4][PW-1:INTENSITY_BITS];
        ic   = win_reg[4][INTENSITY_BITS-1:0];
        diff = '0;
        grad = '0;
        cnt  = '0;
        rn   = '0;
        inn  = '0;
        for (int k = 0; k < 9; k++) begin
            rn  = win_reg[k][PW-1:INTENSITY_BITS];
            inn = win_reg[k][INTENSITY_BITS-1:0];
            if (k != 4 && rn != '0) begin
                diff = diff + DW'((rc > rn) ? rc - rn : rn - rc);
                grad = grad + GW'((ic > inn) ? ic - inn : inn - ic);
                cnt  = cnt + 4'd1;
            end
        end
        ok = inwin_reg && (rc != '0) && (cnt != '0);
    end

    always_comb begin
        q_data.col  = c_reg - 11'd1;
        q_data.row  = r_reg - 12'd1;
        q_data.rc   = RANGE_BITS_MAX'(rc);
        q_data.diff = (RANGE_BITS_MAX + 3)'(diff);
        q_data.grad = (INTENSITY_BITS_MAX + 3)'(grad);
        q_data.cnt  = cnt;
        q_data.clr  = clr_reg;
        q_push      = (state_reg == F_SUM) && ok && !q_full;
    end

    always_comb begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        c_next     = c_reg;
        r_next     = r_reg;
        inwin_next = inwin_reg;
        clr_next   = clr_reg;
        cur_next   = cur_reg;
        for (int k = 0; k < 9; k++) begin
            win_next[k] = win_reg[k];
        end
        c0    = s_data.frame_start ? '0 : col_reg;
        r0    = s_data.frame_start ? '0 : row_reg;
        lw    = WW'(line_width);
        if (lw < WW'(3)) begin
            weff = WW'(3);
        end else if (lw > WW'(LINE_MAX)) begin
            weff = WW'(LINE_MAX);
        end else begin
            weff = lw;
        end
        cplus = WW'(c0) + WW'(1);

        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    c_next     = c0;
                    r_next     = r0;
                    cur_next   = {RANGE_BITS'(s_data.pixel_range),
                                  INTENSITY_BITS'(s_data.pixel_intensity)};
                    inwin_next = (r0 >= 12'd2) && (c0 >= 11'd2) && (WW'(c0) < weff);
                    clr_next   = clr_reg | s_data.frame_start;
                    if (cplus >= weff) begin
                        col_next = '0;
                        row_next = r0 + 12'd1;
                    end else begin
                        col_next = c0 + 11'd1;
                        row_next = r0;
                    end
                    state_next = F_READ;
                end
            end
            F_READ: begin
                state_next = F_WIN;
            end
            F_WIN: begin
                for (int k = 0; k < 3; k++) begin
                    win_next[k*3]     = win_reg[k*3 + 1];
                    win_next[k*3 + 1] = win_reg[k*3 + 2];
                end
                win_next[2] = top_rd;
                win_next[5] = mid_rd;
                win_next[8] = cur_reg;
                state_next  = F_SUM;
            end
            F_SUM: begin
                if (!ok) begin
                    state_next = F_IDLE;
                end else if (!q_full) begin
                    clr_next   = 1'b0;
                    state_next = F_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            inwin_reg <= 1'b0;
            clr_reg   <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            inwin_reg <= inwin_next;
            clr_reg   <= clr_next;
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= win_next[k];
            end
        end
        c_reg   <= c_next;
        r_reg   <= r_next;
        cur_reg <= cur_next;
    end
endmodule
`default_nettype wire

[rtl/core/rifc_back.sv]
// Back end: threshold cross-multiplications, per-frame caps and the output register.
// Depends on rifc_pkg.
`default_nettype none
module rifc_back (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  rifc_pkg::cfg_t        cfg,
    input  wire                   q_empty,
    input  rifc_pkg::entry_t      q_data,
    output logic                  q_pop,
    output logic                  m_valid,
    input  wire                   m_ready,
    output rifc_pkg::out_t        m_data
);
    import rifc_pkg::*;

    typedef enum logic [1:0] {B_IDLE, B_BASE, B_PROD, B_OUT} bstate_t;

    bstate_t       state_reg, state_next;
    entry_t        ent_reg, ent_next;
    logic [27:0]   base_reg, base_next;
    logic [47:0]   pe_reg, pe_next;
    logic [47:0]   ps_reg, ps_next;
    logic [19:0]   pg_reg, pg_next;
    logic [15:0]   ecnt_reg, ecnt_next;
    logic [15:0]   scnt_reg, scnt_next;
    logic [15:0]   icnt_reg, icnt_next;
    logic          mv_reg, mv_next;
    out_t          md_reg, md_next;
    logic [47:0]   scaled;
    logic [1:0]    cls;
    logic          ifeat;

    assign q_pop   = (state_reg == B_IDLE) && !q_empty;
    assign m_valid = mv_reg;
    assign m_data  = md_reg;

    always_comb begin
        state_next = state_reg;
        ent_next   = ent_reg;
        base_next  = base_reg;
        pe_next    = pe_reg;
        ps_next    = ps_reg;
        pg_next    = pg_reg;
        ecnt_next  = ecnt_reg;
        scnt_next  = scnt_reg;
        icnt_next  = icnt_reg;
        mv_next    = mv_reg && !m_ready;
        md_next    = md_reg;
        scaled     = 48'(ent_reg.diff) << 12;
        cls        = CLASS_NONE;
        ifeat      = 1'b0;

        unique case (state_reg)
            B_IDLE: begin
                if (q_pop) begin
                    ent_next = q_data;
                    if (q_data.clr) begin
                        ecnt_next = '0;
                        scnt_next = '0;
                        icnt_next = '0;
                    end
                    state_next = B_BASE;
                end
            end
            B_BASE: begin
                base_next  = 28'(ent_reg.cnt) * 28'(ent_reg.rc);
                state_next = B_PROD;
            end
            B_PROD: begin
                pe_next    = 48'(cfg.edge_threshold) * 48'(base_reg);
                ps_next    = 48'(cfg.surface_threshold) * 48'(base_reg);
                pg_next    = 20'(cfg.gradient_threshold) * 20'(ent_reg.cnt);
                state_next = B_OUT;
            end
            B_OUT: begin
                if (!mv_reg || m_ready) begin
                    if (scaled > pe_reg) begin
                        if (ecnt_reg < cfg.edge_limit) begin
                            cls       = CLASS_EDGE;
                            ecnt_next = ecnt_reg + 16'd1;
                        end
                    end else if (scaled < ps_reg) begin
                        if (scnt_reg < cfg.surface_limit) begin
                            cls       = CLASS_SURFACE;
                            scnt_next = scnt_reg + 16'd1;
                        end
                    end
                    if (cfg.intensity_enable && (ent_reg.grad > 27'(pg_reg))) begin
                        if (icnt_reg < cfg.intensity_limit) begin
                            ifeat     = 1'b1;
                            icnt_next = icnt_reg + 16'd1;
                        end
                    end
                    md_next.center_col        = ent_reg.col;
                    md_next.center_row        = ent_reg.row;
                    md_next.geom_class        = cls;
                    md_next.intensity_feature = ifeat;
                    mv_next    = 1'b1;
                    state_next = B_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            ecnt_reg  <= '0;
            scnt_reg  <= '0;
            icnt_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ecnt_reg  <= ecnt_next;
            scnt_reg  <= scnt_next;
            icnt_reg  <= icnt_next;
            mv_reg    <= mv_next;
        end
        ent_reg  <= ent_next;
        base_reg <= base_next;
        pe_reg   <= pe_next;
        ps_reg   <= ps_next;
        pg_reg   <= pg_next;
        md_reg   <= md_next;
    end
endmodule
`default_nettype wire

[rtl/core/range_image_feature_classifier_core.sv]
// Top level of the range image feature classifier: register file, front end, queue, back end.
// Depends on rifc_pkg, rifc_front, rifc_fifo and rifc_back.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid / s_ready  rifc_pkg::in_t, one pixel per transaction
//   m_        out        m_valid / m_ready  rifc_pkg::out_t, zero or one per pixel
//   APB       in         psel/penable       eight 32-bit registers at 4*index
//
// The front end takes a new pixel transaction only after its read, write back and window
// update sequence on the two line store RAMs and its neighborhood sums state, where it waits
// while the queue is full. The back end takes one classified pixel at a time through its
// two multiplier stages. Reset is synchronous and active low and needs no clearing pass;
// the line store is simply undefined until written. A two-entry queue lets the front end
// keep accepting pixels while the output register waits on m_ready.
`default_nettype none
module range_image_feature_classifier_core #(
    parameter int LINE_MAX       = rifc_pkg::LINE_MAX_DEF,
    parameter int RANGE_BITS     = rifc_pkg::RANGE_BITS_DEF,
    parameter int INTENSITY_BITS = rifc_pkg::INTENSITY_BITS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  rifc_pkg::in_t                s_data,
    output logic                         m_valid,
    input  wire                          m_ready,
    output rifc_pkg::out_t               m_data,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [rifc_pkg::ADDR_W-1:0]  paddr,
    input  wire  [rifc_pkg::DATA_W-1:0]  pwdata,
    output logic [rifc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import rifc_pkg::*;

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;
    logic        q_push, q_pop, q_full, q_empty;
    entry_t      q_wdata, q_rdata;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Configuration writes must be made only while the core is idle; the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_width         <= LINE_WIDTH_RST;
            cfg_reg.edge_threshold     <= EDGE_THRESHOLD_RST;
            cfg_reg.surface_threshold  <= SURFACE_THRESH_RST;
            cfg_reg.gradient_threshold <= GRADIENT_THRESH_RST;
            cfg_reg.edge_limit         <= EDGE_LIMIT_RST;
            cfg_reg.surface_limit      <= SURFACE_LIMIT_RST;
            cfg_reg.intensity_limit    <= INTENSITY_LIMIT_RST;
            cfg_reg.intensity_enable   <= 1'b1;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_LINE_WIDTH:       cfg_reg.line_width         <= pwdata[11:0];
                REG_EDGE_THRESHOLD:   cfg_reg.edge_threshold     <= pwdata[15:0];
                REG_SURFACE_THRESH:   cfg_reg.surface_threshold  <= pwdata[15:0];
                REG_GRADIENT_THRESH:  cfg_reg.gradient_threshold <= pwdata[15:0];
                REG_EDGE_LIMIT:       cfg_reg.edge_limit         <= pwdata[15:0];
                REG_SURFACE_LIMIT:    cfg_reg.surface_limit      <= pwdata[15:0];
                REG_INTENSITY_LIMIT:  cfg_reg.intensity_limit    <= pwdata[15:0];
                REG_INTENSITY_ENABLE: cfg_reg.intensity_enable   <= pwdata[0];
            endcase
        end
    end

    // Register readback is a plain mux on the word index.
    always_comb begin
        unique case (reg_idx)
            REG_LINE_WIDTH:       prdata = DATA_W'(cfg_reg.line_width);
            REG_EDGE_THRESHOLD:   prdata = DATA_W'(cfg_reg.edge_threshold);
            REG_SURFACE_THRESH:   prdata = DATA_W'(cfg_reg.surface_threshold);
            REG_GRADIENT_THRESH:  prdata = DATA_W'(cfg_reg.gradient_threshold);
            REG_EDGE_LIMIT:       prdata = DATA_W'(cfg_reg.edge_limit);
            REG_SURFACE_LIMIT:    prdata = DATA_W'(cfg_reg.surface_limit);
            REG_INTENSITY_LIMIT:  prdata = DATA_W'(cfg_reg.intensity_limit);
            REG_INTENSITY_ENABLE: prdata = DATA_W'(cfg_reg.intensity_enable);
        endcase
    end

    // The front end tracks pixel position and builds the window; a frame start is
    // forwarded as a flag on the next queued transaction so that the back end clears
    // its per-frame counts in order.
    rifc_front #(
        .LINE_MAX      (LINE_MAX),
        .RANGE_BITS    (RANGE_BITS),
        .INTENSITY_BITS(INTENSITY_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .line_width(cfg_reg.line_width),
        .q_push    (q_push),
        .q_data    (q_wdata),
        .q_full    (q_full)
    );

    rifc_fifo #(.WIDTH($bits(entry_t)), .DEPTH(2)) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .wdata  (q_wdata),
        .full   (q_full),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .empty  (q_empty)
    );

    // The back end performs the exact threshold tests and applies the caps.
    rifc_back u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cfg    (cfg_reg),
        .q_empty(q_empty),
        .q_data (q_rdata),
        .q_pop  (q_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );
endmodule
`default_nettype wire

[rtl/core/rifc_checker.sv]
// Port-level checker for the classifier core, bound to the top level.
// Depends on rifc_pkg and range_image_feature_classifier_core.
`default_nettype none
module rifc_checker (
    input wire             aclk,
    input wire             aresetn,
    input wire             s_valid,
    input wire             s_ready,
    input wire             m_valid,
    input wire             m_ready,
    input rifc_pkg::out_t  m_data,
    input wire             pready
);
    import rifc_pkg::*;

    // A synchronous reset leaves no result pending.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // The front end is busy after each accepted pixel, so it never accepts pixels back to back.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("pixel accepted on back-to-back cycles");

    // Class code three is never produced.
    a_class_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.geom_class == CLASS_NONE || m_data.geom_class == CLASS_EDGE ||
                     m_data.geom_class == CLASS_SURFACE))
        else $error("illegal class code");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");
endmodule

bind range_image_feature_classifier_core rifc_checker u_rifc_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data),
    .pready (pready)
);
`default_nettype wire
